// ===== rtl/vap_pkg.sv =====
package vap_pkg;

  localparam int VOICES = 8;
  localparam int VW     = 3;
  localparam int KEY_W  = 7;
  localparam int CNT_W  = 4;

  localparam int REG_LIMIT = 0;
  localparam int REG_MONO  = 1;

  typedef enum logic [2:0] {
    MODE_FIND    = 3'd0,
    MODE_FINDALL = 3'd1,
    MODE_ALLOC   = 3'd2,
    MODE_MOVE    = 3'd3,
    MODE_REL     = 3'd4,
    MODE_SETF    = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_PEND,
    KIND_FRONT,
    KIND_STEAL,
    KIND_REL,
    KIND_SEL
  } kind_e;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_SHIFT,
    RD_LAST
  } rd_e;

  typedef struct packed {
    logic  load_item;
    logic  step;
    logic  cnt_inc;
    logic  alloc_set;
    logic  shift_free;
    logic  shift_steal;
    logic  shift_move;
    logic  shift_step;
    logic  rel_step;
    logic  rel_done;
    logic  set_foreign;
    logic  pend_set;
    logic  out_load;
    kind_e out_kind;
    logic  out_last;
    rd_e   rd_sel;
  } cmd_t;

  typedef struct packed {
    logic              scan_end;
    logic              hit_find;
    logic              hit_all;
    logic              sel_match;
    logic              vend;
    logic              alloc_i;
    logic              cnt_ok;
    logic              count_zero;
    logic              p_zero;
    logic              pend_valid;
    logic              out_busy;
    logic [CNT_W-1:0]  count;
    logic [VOICES-1:0] alloc_vec;
  } stat_t;

endpackage

// ===== rtl/vap_ctrl.sv =====
module vap_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [2:0]    mode,
  input  vap_pkg::stat_t stat,
  output logic          in_ready,
  output vap_pkg::cmd_t cmd
);
  import vap_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_ALLOC = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  kind_e  kind, kind_next;
  logic [2:0] mode_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= KIND_NONE;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
    if (cmd.load_item) mode_q <= mode;
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_SCAN;
    cmd.out_kind = KIND_NONE;
    state_next = state;
    kind_next  = kind;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (mode_e'(mode))
            MODE_FIND, MODE_FINDALL, MODE_MOVE, MODE_REL: state_next = S_SCAN;
            MODE_ALLOC: state_next = S_ALLOC;
            MODE_SETF: begin
              // voice_sel always addresses a voice
              cmd.set_foreign = 1'b1;
              kind_next  = KIND_SEL;
              state_next = S_DONE;
            end
            default: begin
              kind_next  = KIND_NONE;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        case (mode_e'(mode_q))
          MODE_FIND: begin
            if (stat.scan_end) begin
              kind_next  = KIND_NONE;
              state_next = S_DONE;
            end else if (stat.hit_find) begin
              cmd.pend_set = 1'b1;
              kind_next  = KIND_PEND;
              state_next = S_DONE;
            end else begin
              cmd.step = 1'b1;
            end
          end
          MODE_FINDALL: begin
            if (stat.scan_end) begin
              kind_next  = stat.pend_valid ? KIND_PEND : KIND_NONE;
              state_next = S_DONE;
            end else if (stat.hit_all) begin
              // hold the previous hit until the next one shows it is not last
              if (!stat.pend_valid) begin
                cmd.pend_set = 1'b1;
                cmd.step     = 1'b1;
              end else if (!stat.out_busy) begin
                cmd.out_load = 1'b1;
                cmd.out_kind = KIND_PEND;
                cmd.pend_set = 1'b1;
                cmd.step     = 1'b1;
              end
            end else begin
              cmd.step = 1'b1;
            end
          end
          MODE_MOVE: begin
            if (stat.scan_end) begin
              kind_next  = KIND_NONE;
              state_next = S_DONE;
            end else if (stat.sel_match) begin
              cmd.shift_move = 1'b1;
              kind_next  = KIND_FRONT;
              state_next = S_SHIFT;
            end else begin
              cmd.step = 1'b1;
            end
          end
          default: begin
            if (stat.scan_end) begin
              cmd.rel_done = 1'b1;
              kind_next  = KIND_REL;
              state_next = S_DONE;
            end else begin
              cmd.rel_step = 1'b1;
              cmd.step     = 1'b1;
            end
          end
        endcase
      end
      S_ALLOC: begin
        cmd.rd_sel = RD_LAST;
        if (!stat.vend && stat.cnt_ok) begin
          if (stat.alloc_i) begin
            cmd.cnt_inc = 1'b1;
            cmd.step    = 1'b1;
          end else begin
            cmd.alloc_set  = 1'b1;
            cmd.shift_free = 1'b1;
            kind_next  = KIND_FRONT;
            state_next = S_SHIFT;
          end
        end else if (stat.count_zero) begin
          kind_next  = KIND_NONE;
          state_next = S_DONE;
        end else begin
          cmd.shift_steal = 1'b1;
          kind_next  = KIND_STEAL;
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.rd_sel     = RD_SHIFT;
        cmd.shift_step = 1'b1;
        if (stat.p_zero) state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = kind;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/vap_datapath.sv =====
module vap_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  vap_pkg::cmd_t                 cmd,
  output vap_pkg::stat_t                stat,
  input  logic [vap_pkg::KEY_W-1:0]     note_key,
  input  logic [vap_pkg::VW-1:0]        voice_sel,
  input  logic                          foreign_flag,
  input  logic [vap_pkg::VOICES-1:0]    finished_mask,
  input  logic [vap_pkg::CNT_W-1:0]     limit,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [vap_pkg::VW-1:0]        voice_num,
  output logic                          found,
  output logic                          stolen,
  output logic [vap_pkg::VOICES-1:0]    released_mask,
  output logic                          last
);
  import vap_pkg::*;

  logic [VW-1:0]     order_list [VOICES];
  logic [CNT_W-1:0]  order_count;
  logic [VOICES-1:0] alloc_marks;
  logic [VOICES-1:0] foreign_marks;
  logic [KEY_W-1:0]  voice_keys [VOICES];

  logic [KEY_W-1:0]  key_q;
  logic [VW-1:0]     sel_q;
  logic [VOICES-1:0] mask_q;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  keep;
  logic [VW-1:0]     ptr;
  logic [VW-1:0]     front_v;
  logic [VW-1:0]     pend_v;
  logic              pend_valid;
  logic [VOICES-1:0] rel;

  logic [VW-1:0] rd_addr;
  logic [VW-1:0] rd_v;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_SHIFT: rd_addr = ptr - VW'(1);
      RD_LAST:  rd_addr = order_count[VW-1:0] - VW'(1);
      default:  rd_addr = idx[VW-1:0];
    endcase
  end

  assign rd_v = order_list[rd_addr];

  always_comb begin
    stat            = '0;
    stat.scan_end   = (idx == order_count);
    stat.hit_all    = (voice_keys[rd_v] == key_q) && alloc_marks[rd_v];
    stat.hit_find   = stat.hit_all && !foreign_marks[rd_v];
    stat.sel_match  = (rd_v == sel_q);
    stat.vend       = (idx == CNT_W'(VOICES));
    stat.alloc_i    = alloc_marks[idx[VW-1:0]];
    stat.cnt_ok     = (cnt < limit);
    stat.count_zero = (order_count == '0);
    stat.p_zero     = (ptr == '0);
    stat.pend_valid = pend_valid;
    stat.out_busy   = out_valid && !out_ready;
    stat.count      = order_count;
    stat.alloc_vec  = alloc_marks;
  end

  // order list holds no reset value; only the first order_count entries are read
  always_ff @(posedge clk) begin
    if (cmd.shift_step) begin
      if (ptr != '0) order_list[ptr] <= rd_v;
      else order_list[0] <= front_v;
    end
    if (cmd.rel_step && !mask_q[rd_v]) order_list[keep[VW-1:0]] <= rd_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order_count   <= '0;
      alloc_marks   <= '0;
      foreign_marks <= '0;
      for (int v = 0; v < VOICES; v++) voice_keys[v] <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.load_item) pend_valid <= 1'b0;
      if (cmd.pend_set) pend_valid <= 1'b1;
      if (cmd.set_foreign) foreign_marks[voice_sel] <= foreign_flag;
      if (cmd.alloc_set) begin
        alloc_marks[idx[VW-1:0]] <= 1'b1;
        voice_keys[idx[VW-1:0]]  <= key_q;
      end
      if (cmd.shift_free) order_count <= order_count + CNT_W'(1);
      if (cmd.shift_steal) voice_keys[rd_v] <= key_q;
      if (cmd.rel_step && mask_q[rd_v]) alloc_marks[rd_v] <= 1'b0;
      if (cmd.rel_done) order_count <= keep;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      key_q  <= note_key;
      sel_q  <= voice_sel;
      mask_q <= finished_mask;
      idx    <= '0;
      cnt    <= '0;
      keep   <= '0;
      rel    <= '0;
    end else begin
      if (cmd.step) idx <= idx + CNT_W'(1);
      if (cmd.cnt_inc) cnt <= cnt + CNT_W'(1);
      if (cmd.rel_step) begin
        if (mask_q[rd_v]) rel[rd_v] <= 1'b1;
        else keep <= keep + CNT_W'(1);
      end
    end
    if (cmd.pend_set) pend_v <= rd_v;
    if (cmd.shift_free) begin
      ptr     <= order_count[VW-1:0];
      front_v <= idx[VW-1:0];
    end
    if (cmd.shift_steal) begin
      ptr     <= order_count[VW-1:0] - VW'(1);
      front_v <= rd_v;
    end
    if (cmd.shift_move) begin
      ptr     <= idx[VW-1:0];
      front_v <= sel_q;
    end
    if (cmd.shift_step && ptr != '0) ptr <= ptr - VW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      last <= cmd.out_last;
      unique case (cmd.out_kind)
        KIND_PEND: begin
          voice_num     <= pend_v;
          found         <= 1'b1;
          stolen        <= 1'b0;
          released_mask <= '0;
        end
        KIND_FRONT: begin
          voice_num     <= front_v;
          found         <= 1'b1;
          stolen        <= 1'b0;
          released_mask <= '0;
        end
        KIND_STEAL: begin
          voice_num     <= front_v;
          found         <= 1'b1;
          stolen        <= 1'b1;
          released_mask <= '0;
        end
        KIND_REL: begin
          voice_num     <= '0;
          found         <= 1'b0;
          stolen        <= 1'b0;
          released_mask <= rel;
        end
        KIND_SEL: begin
          voice_num     <= sel_q;
          found         <= 1'b1;
          stolen        <= 1'b0;
          released_mask <= '0;
        end
        default: begin
          voice_num     <= '0;
          found         <= 1'b0;
          stolen        <= 1'b0;
          released_mask <= '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/voice_allocator_lru_steal_top.sv =====
// Voice allocator for an eight-voice synthesizer with least-recent stealing. One input
// transfer carries one mode; every mode gives one result transfer except find all, which
// gives one per matching voice in most-recent-first order with last on the final one.
// Set foreign and the unused modes go straight to their result, a scan of the order list
// takes one entry a cycle, allocate walks the voices by number one a cycle, and a move to
// the front then shifts the list one entry a cycle; find all also waits on the output register
// between results, and each final result waits for it too. Input is taken only
// while the controller is idle, which includes while the last result still waits in the
// output register. Registers: voice_limit at address 0, mono_mode at address 4; write
// them only while idle.
module voice_allocator_lru_steal_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 mode,
  input  logic [vap_pkg::KEY_W-1:0]  note_key,
  input  logic [vap_pkg::VW-1:0]     voice_sel,
  input  logic                       foreign_flag,
  input  logic [vap_pkg::VOICES-1:0] finished_mask,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [vap_pkg::VW-1:0]     voice_num,
  output logic                       found,
  output logic                       stolen,
  output logic [vap_pkg::VOICES-1:0] released_mask,
  output logic                       last
);
  import vap_pkg::*;

  logic [CNT_W-1:0] voice_limit;
  logic             mono_mode;
  logic [CNT_W-1:0] limit;
  logic             wr_en;
  cmd_t             cmd;
  stat_t            stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_limit <= CNT_W'(VOICES);
      mono_mode   <= 1'b0;
    end else if (wr_en) begin
      if (paddr[2] == 1'(REG_LIMIT)) voice_limit <= pwdata[CNT_W-1:0];
      if (paddr[2] == 1'(REG_MONO)) mono_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == 1'(REG_MONO)) ? {31'b0, mono_mode}
                                             : {{(32-CNT_W){1'b0}}, voice_limit};

  assign limit = mono_mode ? CNT_W'(1) : voice_limit;

  vap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  vap_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .note_key      (note_key),
    .voice_sel     (voice_sel),
    .foreign_flag  (foreign_flag),
    .finished_mask (finished_mask),
    .limit         (limit),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .voice_num     (voice_num),
    .found         (found),
    .stolen        (stolen),
    .released_mask (released_mask),
    .last          (last)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(VOICES))
    else $error("order count above voice count");

  a_count_marks: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> ($countones(stat.alloc_vec) == 32'(stat.count)))
    else $error("order list out of step with allocated marks");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !stat.out_busy)
    else $error("result loaded over a pending transfer");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while busy");

endmodule

// ===== tb/voice_allocator_lru_steal_top_tb.sv =====
module voice_allocator_lru_steal_top_tb;
  import vap_pkg::*;

  localparam logic [2:0] MODE_RSVD_A = 3'd6;
  localparam logic [2:0] MODE_RSVD_B = 3'd7;
  localparam int WDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 30;
  localparam int RAND_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 36;

  typedef struct packed {
    logic [2:0]        mode;
    logic [KEY_W-1:0]  key;
    logic [VW-1:0]     sel;
    logic              ff;
    logic [VOICES-1:0] fmask;
  } note_req_t;

  typedef struct packed {
    logic [VW-1:0]     voice_num;
    logic              found;
    logic              stolen;
    logic [VOICES-1:0] released_mask;
    logic              last;
  } voice_evt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] mode = '0;
  logic [KEY_W-1:0] note_key = '0;
  logic [VW-1:0] voice_sel = '0;
  logic foreign_flag = 1'b0;
  logic [VOICES-1:0] finished_mask = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [VW-1:0] voice_num;
  logic found;
  logic stolen;
  logic [VOICES-1:0] released_mask;
  logic last;

  voice_allocator_lru_steal_top u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .note_key(note_key), .voice_sel(voice_sel),
    .foreign_flag(foreign_flag), .finished_mask(finished_mask),
    .out_valid(out_valid), .out_ready(out_ready),
    .voice_num(voice_num), .found(found), .stolen(stolen),
    .released_mask(released_mask), .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // allocator shadow state
  logic [VW-1:0]    order_q [VOICES];
  int               order_len = 0;
  logic             alloc_mark [VOICES];
  logic             foreign_mark [VOICES];
  logic [KEY_W-1:0] key_of [VOICES];
  logic [3:0]       limit_r = 4'd8;
  logic             mono_r = 1'b0;

  note_req_t  note_reqs[$];
  voice_evt_t expected_events[$];

  int errors = 0;
  int reqs_sent = 0;
  int events_checked = 0;
  int steals_seen = 0;
  int settings_used = 1;
  bit no_idle = 1'b0;

  initial begin
    for (int v = 0; v < VOICES; v++) begin
      alloc_mark[v] = 1'b0;
      foreign_mark[v] = 1'b0;
      key_of[v] = '0;
      order_q[v] = '0;
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic move_to_front(input int pos);
    logic [VW-1:0] v;
    v = order_q[pos];
    for (int p = pos; p > 0; p--) order_q[p] = order_q[p-1];
    order_q[0] = v;
  endtask

  task automatic add_event(input voice_evt_t ev);
    expected_events = {expected_events, ev};
  endtask

  task automatic predict_voice_events(input note_req_t r);
    voice_evt_t e;
    voice_evt_t hits[$];
    logic [VW-1:0] v;
    logic [VOICES-1:0] rel;
    int lim, cnt, keep;
    bit done;
    e = '0;
    e.last = 1'b1;
    done = 1'b0;
    case (r.mode)
      MODE_FIND: begin
        for (int i = 0; i < order_len; i++) begin
          v = order_q[i];
          if (!done && key_of[v] == r.key && alloc_mark[v] && !foreign_mark[v]) begin
            e.voice_num = v;
            e.found = 1'b1;
            done = 1'b1;
          end
        end
        add_event(e);
      end
      MODE_FINDALL: begin
        for (int i = 0; i < order_len; i++) begin
          v = order_q[i];
          if (key_of[v] == r.key && alloc_mark[v] && hits.size() < VOICES) begin
            e = '0;
            e.voice_num = v;
            e.found = 1'b1;
            hits = {hits, e};
          end
        end
        if (hits.size() == 0) begin
          e = '0;
          e.last = 1'b1;
          add_event(e);
        end else begin
          hits[hits.size()-1].last = 1'b1;
          foreach (hits[k]) add_event(hits[k]);
        end
      end
      MODE_ALLOC: begin
        lim = mono_r ? 1 : int'(limit_r);
        cnt = 0;
        for (int i = 0; i < VOICES && cnt < lim && !done; i++) begin
          if (alloc_mark[i]) begin
            cnt++;
          end else begin
            alloc_mark[i] = 1'b1;
            key_of[i] = r.key;
            for (int p = order_len; p > 0; p--) order_q[p] = order_q[p-1];
            order_q[0] = VW'(i);
            order_len++;
            e.voice_num = VW'(i);
            e.found = 1'b1;
            done = 1'b1;
          end
        end
        if (!done && order_len != 0) begin
          move_to_front(order_len - 1);
          key_of[order_q[0]] = r.key;
          e.voice_num = order_q[0];
          e.found = 1'b1;
          e.stolen = 1'b1;
        end
        add_event(e);
      end
      MODE_MOVE: begin
        for (int i = 0; i < order_len && !done; i++) begin
          if (order_q[i] == r.sel) begin
            move_to_front(i);
            e.voice_num = r.sel;
            e.found = 1'b1;
            done = 1'b1;
          end
        end
        add_event(e);
      end
      MODE_REL: begin
        keep = 0;
        rel = '0;
        for (int i = 0; i < order_len; i++) begin
          v = order_q[i];
          if (r.fmask[v]) begin
            alloc_mark[v] = 1'b0;
            rel[v] = 1'b1;
          end else begin
            order_q[keep] = v;
            keep++;
          end
        end
        order_len = keep;
        e.released_mask = rel;
        add_event(e);
      end
      MODE_SETF: begin
        foreign_mark[r.sel] = r.ff;
        e.voice_num = r.sel;
        e.found = 1'b1;
        add_event(e);
      end
      default: add_event(e);
    endcase
  endtask

  // request driver
  note_req_t cur_req;
  bit drv_busy = 1'b0;
  int drv_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      drv_busy = 1'b0;
      drv_gap = 0;
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_voice_events(cur_req);
        reqs_sent++;
        drv_busy = 1'b0;
        drv_gap = rand_gap();
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (note_reqs.size() > 0) begin
          cur_req = note_reqs.pop_front();
          drv_busy = 1'b1;
          mode <= cur_req.mode;
          note_key <= cur_req.key;
          voice_sel <= cur_req.sel;
          foreign_flag <= cur_req.ff;
          finished_mask <= cur_req.fmask;
        end
      end
      in_valid <= drv_busy;
    end
  end

  // result monitor
  int mon_stall = 0;
  voice_evt_t want;

  always @(posedge clk) begin
    if (rst) begin
      mon_stall = 0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result transfer: voice_num %0d found %0b", voice_num, found);
          errors++;
        end else begin
          want = expected_events.pop_front();
          events_checked++;
          if (stolen) steals_seen++;
          if (voice_num !== want.voice_num) begin
            $error("voice_num: expected %0d, actual %0d", want.voice_num, voice_num);
            errors++;
          end
          if (found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, found);
            errors++;
          end
          if (stolen !== want.stolen) begin
            $error("stolen: expected %0b, actual %0b", want.stolen, stolen);
            errors++;
          end
          if (released_mask !== want.released_mask) begin
            $error("released_mask: expected %02h, actual %02h",
                   want.released_mask, released_mask);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last);
            errors++;
          end
        end
        mon_stall = rand_gap();
      end else if (mon_stall == 0 && $urandom_range(0, 19) == 0) begin
        mon_stall = rand_gap();
      end
      if (mon_stall > 0) begin
        mon_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: no transfer on any port for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic push_req(input logic [2:0] m, input logic [KEY_W-1:0] k,
                          input logic [VW-1:0] s, input logic f,
                          input logic [VOICES-1:0] fm);
    note_req_t r;
    r.mode = m;
    r.key = k;
    r.sel = s;
    r.ff = f;
    r.fmask = fm;
    note_reqs = {note_reqs, r};
  endtask

  function automatic note_req_t random_req();
    note_req_t r;
    int m, ks;
    m = $urandom_range(0, 99);
    if (m < 30) r.mode = MODE_ALLOC;
    else if (m < 45) r.mode = MODE_FIND;
    else if (m < 58) r.mode = MODE_FINDALL;
    else if (m < 68) r.mode = MODE_MOVE;
    else if (m < 80) r.mode = MODE_REL;
    else if (m < 92) r.mode = MODE_SETF;
    else if (m < 96) r.mode = MODE_RSVD_A;
    else r.mode = MODE_RSVD_B;
    // a small key pool keeps finds hitting
    ks = $urandom_range(0, 9);
    case (ks)
      0, 1: r.key = 7'd0;
      2, 3: r.key = 7'd127;
      4, 5: r.key = 7'd60;
      6, 7: r.key = 7'd61;
      default: r.key = KEY_W'($urandom_range(0, 127));
    endcase
    r.sel = VW'($urandom_range(0, VOICES - 1));
    r.ff = ($urandom_range(0, 9) < 3);
    ks = $urandom_range(0, 9);
    if (ks < 5) r.fmask = VOICES'($urandom_range(0, 255));
    else if (ks < 8) r.fmask = VOICES'(1) << $urandom_range(0, VOICES - 1);
    else r.fmask = '0;
    return r;
  endfunction

  task automatic write_reg(input int idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_LIMIT) limit_r = value[3:0];
    else if (idx == REG_MONO) mono_r = value[0];
  endtask

  task automatic drain();
    while (note_reqs.size() != 0 || drv_busy || expected_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  int ph_limit [RAND_PHASES] = '{15, 1, 8, 0, 3, 8, 0};
  int ph_mono  [RAND_PHASES] = '{0, 0, 1, 0, 0, 0, 0};

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, key extremes, foreign skip, moves, release, unused modes, steal
    push_req(MODE_FIND, 7'd0, 3'd0, 1'b0, 8'h00);
    push_req(MODE_FINDALL, 7'd0, 3'd0, 1'b0, 8'h00);
    push_req(MODE_MOVE, 7'd0, 3'd7, 1'b0, 8'h00);
    push_req(MODE_ALLOC, 7'd0, 3'd0, 1'b0, 8'h00);
    push_req(MODE_ALLOC, 7'd127, 3'd0, 1'b0, 8'h00);
    push_req(MODE_ALLOC, 7'd127, 3'd0, 1'b0, 8'h00);
    push_req(MODE_FINDALL, 7'd127, 3'd0, 1'b0, 8'h00);
    push_req(MODE_FIND, 7'd127, 3'd0, 1'b0, 8'h00);
    push_req(MODE_SETF, 7'd0, 3'd2, 1'b1, 8'h00);
    push_req(MODE_FIND, 7'd127, 3'd0, 1'b0, 8'h00);
    push_req(MODE_FINDALL, 7'd127, 3'd7, 1'b1, 8'hFF);
    push_req(MODE_MOVE, 7'd0, 3'd1, 1'b0, 8'h00);
    push_req(MODE_SETF, 7'd0, 3'd0, 1'b0, 8'h00);
    push_req(MODE_REL, 7'd0, 3'd0, 1'b0, 8'hFA);
    push_req(MODE_RSVD_A, 7'd127, 3'd7, 1'b1, 8'hFF);
    push_req(MODE_RSVD_B, 7'd127, 3'd7, 1'b1, 8'hFF);
    for (int i = 0; i < 6; i++) push_req(MODE_ALLOC, 7'd127, 3'd0, 1'b0, 8'h00);
    push_req(MODE_ALLOC, 7'd42, 3'd0, 1'b0, 8'h00);
    drain();

    // zero limit with an empty list: nothing to steal
    write_reg(REG_LIMIT, 32'd0);
    write_reg(REG_MONO, 32'd0);
    settings_used++;
    push_req(MODE_REL, 7'd0, 3'd0, 1'b0, 8'hFF);
    push_req(MODE_ALLOC, 7'd127, 3'd0, 1'b0, 8'h00);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) begin
        ph_limit[ph] = $urandom_range(0, 15);
        ph_mono[ph] = $urandom_range(0, 1);
      end
      write_reg(REG_LIMIT, 32'(ph_limit[ph]));
      write_reg(REG_MONO, 32'(ph_mono[ph]));
      settings_used++;
      no_idle = (ph % 3 == 2);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) note_reqs = {note_reqs, random_req()};
      drain();
    end

    $display("Sent %0d note requests over %0d register settings (limits 0..15, mono on/off)",
             reqs_sent, settings_used);
    $display("Checked %0d result transfers, %0d of them steals", events_checked, steals_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/vap_pkg.sv
rtl/vap_ctrl.sv
rtl/vap_datapath.sv
rtl/voice_allocator_lru_steal_top.sv
tb/voice_allocator_lru_steal_top_tb.sv
